/* hdl/tts_pkg.sv */
// Shared types and constants for the tick task scheduler table.
// No dependencies; used by tts_cell, tts_head and the top file in hdl.
package tts_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  typedef enum logic [1:0] {
    CMD_ADD      = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_DELETE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_TICKED   = 3'd2,
    ST_RUN      = 3'd3,
    ST_NONE     = 3'd4,
    ST_DELETED  = 3'd5,
    ST_EMPTY    = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_DIV,
    FSM_WALK,
    FSM_EMIT,
    FSM_OUT
  } fsm_t;

  // One slot's contents as it travels round the ring.
  typedef struct packed {
    logic [7:0]  handle;
    logic [23:0] delay;
    logic [23:0] period;
    logic [7:0]  pending;
  } slot_t;

  // Operation applied by the head cell as a slot passes.
  typedef struct packed {
    logic        shift;
    cmd_t        cmd;
    logic        do_add;
    logic        do_run;
    logic        do_del;
    logic [7:0]  handle;
    logic [23:0] delay;
    logic [23:0] period;
  } head_ctl_t;

endpackage

/* hdl/tts_cell.sv */
// One storage cell of the slot ring; passes its slot to the next cell on shift.
// Depends on tts_pkg.
module tts_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift,
  input  tts_pkg::slot_t  slot_in,
  output tts_pkg::slot_t  slot_out
);

  tts_pkg::slot_t slot_r;
  tts_pkg::slot_t slot_nxt;

  // hold unless the ring advances
  always_comb begin
    slot_nxt = shift ? slot_in : slot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  assign slot_out = slot_r;

endmodule

/* hdl/tts_head.sv */
// Head cell logic: updates the slot leaving the ring's last cell before it
// re-enters cell 0. Depends on tts_pkg.
module tts_head (
  input  tts_pkg::head_ctl_t ctl,
  input  tts_pkg::slot_t     slot_in,
  output tts_pkg::slot_t     slot_out
);

  always_comb begin
    slot_out = slot_in;
    if (ctl.do_add) begin
      slot_out.handle  = ctl.handle;
      slot_out.delay   = ctl.delay;
      slot_out.period  = ctl.period;
      slot_out.pending = '0;
    end else if (ctl.do_del) begin
      slot_out = '0;
    end else if (ctl.do_run) begin
      // one-shot tasks leave once run
      if (slot_in.period == '0) begin
        slot_out = '0;
      end else begin
        slot_out.pending = slot_in.pending - 8'd1;
      end
    end else if (ctl.cmd == tts_pkg::CMD_TICK && slot_in.handle != '0) begin
      if (slot_in.delay == '0) begin
        if (slot_in.pending != 8'hFF) slot_out.pending = slot_in.pending + 8'd1;
        if (slot_in.period != '0) slot_out.delay = slot_in.period;
      end else begin
        slot_out.delay = slot_in.delay - 24'd1;
      end
    end
  end

endmodule

/* hdl/tts_div.sv */
// Restoring divider: delay and period by the tick length, one bit a cycle each.
// No dependencies; no submodules.
module tts_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [23:0] num_a,
  input  logic [23:0] num_b,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic [23:0] quo_a,
  output logic [23:0] quo_b
);

  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [23:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [10:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [9:0]  d_r, d_nxt;
  logic [10:0] ta, tb;

  // shift in one dividend bit and subtract where it fits
  always_comb begin
    cnt_nxt = cnt_r; busy_nxt = busy_r;
    qa_nxt = qa_r; qb_nxt = qb_r; ra_nxt = ra_r; rb_nxt = rb_r; d_nxt = d_r;
    ta = {ra_r[9:0], qa_r[23]};
    tb = {rb_r[9:0], qb_r[23]};
    if (start) begin
      busy_nxt = 1'b1; cnt_nxt = 5'd0;
      qa_nxt = num_a; qb_nxt = num_b; ra_nxt = '0; rb_nxt = '0;
      d_nxt = (divisor == '0) ? 10'd1 : divisor;
    end else if (busy_r) begin
      if (ta >= {1'b0, d_r}) begin
        ra_nxt = ta - {1'b0, d_r}; qa_nxt = {qa_r[22:0], 1'b1};
      end else begin
        ra_nxt = ta; qa_nxt = {qa_r[22:0], 1'b0};
      end
      if (tb >= {1'b0, d_r}) begin
        rb_nxt = tb - {1'b0, d_r}; qb_nxt = {qb_r[22:0], 1'b1};
      end else begin
        rb_nxt = tb; qb_nxt = {qb_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    qa_r <= qa_nxt; qb_r <= qb_nxt; ra_r <= ra_nxt; rb_r <= rb_nxt; d_r <= d_nxt;
  end

  assign busy  = busy_r;
  assign quo_a = qa_r;
  assign quo_b = qb_r;

endmodule

/* hdl/tick_task_scheduler_table_top.sv */
// Tick task scheduler table: ring of slot cells walked one full turn per walked command.
// Sequence: an add goes from acceptance through a divider start, 24 divide steps, a
// hand-over, SLOT_COUNT walk steps and an emit to its word; add with handle zero yields
// no word and is not walked; other commands go through the walk steps and the emit to
// the final word; a stalled output holds a dispatch walk and the emit. Throughput: one
// command at a time; the next is taken only once the last output word has been taken.
// Reset: synchronous, active low; all slots empty, tick length 10.
// Depends on tts_pkg, tts_cell, tts_head, tts_div.
module tick_task_scheduler_table_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [9:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_task_handle,
  input  logic [23:0] in_delay_ms,
  input  logic [23:0] in_period_ms,
  input  logic [3:0]  in_slot_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_run_handle,
  output logic [3:0]  out_slot_used,
  output logic        out_last_result
);

  localparam int N = tts_pkg::SLOT_COUNT;
  localparam int CW = tts_pkg::CNT_W;

  logic [9:0] tick_len_r;

  tts_pkg::fsm_t state_r, state_nxt;
  tts_pkg::cmd_t cmd_r, cmd_nxt;
  logic [7:0]  hnd_r, hnd_nxt;
  logic [3:0]  sn_r, sn_nxt;
  logic [23:0] dly_r, dly_nxt, per_r, per_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic        added_r, added_nxt;
  logic        found_r, found_nxt;
  logic [CW-1:0] nrun_r, nrun_nxt;
  logic [3:0]  slot_w_r, slot_w_nxt;
  logic [7:0]  rh_r, rh_nxt;
  logic [3:0]  rs_r, rs_nxt;
  logic        ov_r, ov_nxt;
  logic [2:0]  o_st_r, o_st_nxt;
  logic [7:0]  o_h_r, o_h_nxt;
  logic [3:0]  o_s_r, o_s_nxt;
  logic        o_l_r, o_l_nxt;

  logic        div_start, div_busy;
  logic [23:0] qa, qb;

  tts_pkg::slot_t   ring [N];
  tts_pkg::slot_t   head_out;
  tts_pkg::head_ctl_t ctl;
  logic [3:0]       pos4;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) tick_len_r <= 10'd10;
    else if (cfg_we) tick_len_r <= cfg_wdata;
  end

  tts_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num_a(dly_r), .num_b(per_r), .divisor(tick_len_r),
    .busy(div_busy), .quo_a(qa), .quo_b(qb)
  );

  // ring of cells: the last cell feeds the head logic, which feeds cell 0
  tts_head u_head (.ctl(ctl), .slot_in(ring[N-1]), .slot_out(head_out));

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_first
      tts_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(ctl.shift),
                       .slot_in(head_out), .slot_out(ring[g]));
    end else begin : g_rest
      tts_cell u_cell (.clk(clk), .rst_n(rst_n), .shift(ctl.shift),
                       .slot_in(ring[g-1]), .slot_out(ring[g]));
    end
  end

  // the slot at the head has index pos_r during a walk
  assign pos4 = 4'(pos_r);

  // sequence one command through divide, walk and emit
  always_comb begin
    state_nxt = state_r; cmd_nxt = cmd_r; hnd_nxt = hnd_r; sn_nxt = sn_r;
    dly_nxt = dly_r; per_nxt = per_r; pos_nxt = pos_r; added_nxt = added_r;
    found_nxt = found_r; nrun_nxt = nrun_r; slot_w_nxt = slot_w_r;
    rh_nxt = rh_r; rs_nxt = rs_r;
    ov_nxt = ov_r; o_st_nxt = o_st_r; o_h_nxt = o_h_r; o_s_nxt = o_s_r;
    o_l_nxt = o_l_r;
    div_start = 1'b0;
    ctl = '0;
    ctl.cmd = cmd_r;
    ctl.handle = hnd_r;
    ctl.delay = qa;
    ctl.period = qb;
    in_stall = (state_r != tts_pkg::FSM_IDLE);

    if (ov_r && !out_stall) ov_nxt = 1'b0;

    case (state_r)
      tts_pkg::FSM_IDLE: begin
        if (in_valid && !ov_r) begin
          cmd_nxt = tts_pkg::cmd_t'(in_command);
          hnd_nxt = in_task_handle; sn_nxt = in_slot_number;
          dly_nxt = in_delay_ms; per_nxt = in_period_ms;
          pos_nxt = '0; added_nxt = 1'b0; found_nxt = 1'b0; nrun_nxt = '0;
          if (tts_pkg::cmd_t'(in_command) == tts_pkg::CMD_ADD) begin
            if (in_task_handle != '0) state_nxt = tts_pkg::FSM_DIV;
          end else begin
            state_nxt = tts_pkg::FSM_WALK;
          end
        end else begin
          in_stall = 1'b1;
        end
      end
      tts_pkg::FSM_DIV: begin
        if (!div_busy && !found_r) begin
          div_start = 1'b1; found_nxt = 1'b1;
        end else if (!div_busy && found_r) begin
          found_nxt = 1'b0; state_nxt = tts_pkg::FSM_WALK;
        end
      end
      tts_pkg::FSM_WALK: begin
        // act on the slot at the head, then advance the ring one place unless a dispatch is held
        ctl.shift = 1'b1;
        case (cmd_r)
          tts_pkg::CMD_ADD: begin
            if (!added_r && ring[N-1].handle == '0) begin
              ctl.do_add = 1'b1; added_nxt = 1'b1; slot_w_nxt = pos4;
            end
          end
          tts_pkg::CMD_DELETE: begin
            if ({{(8-CW){1'b0}}, pos_r} == {4'd0, sn_r} && ring[N-1].handle != '0) begin
              ctl.do_del = 1'b1; found_nxt = 1'b1; o_h_nxt = ring[N-1].handle;
            end
          end
          tts_pkg::CMD_DISPATCH: begin
            // hold the newest run word; send the one held before it as not last
            if (ring[N-1].pending != '0) begin
              ctl.do_run = 1'b1;
              ctl.shift = (nrun_r == '0) || !ov_r || !out_stall;
              if (ctl.shift) begin
                if (nrun_r != '0) begin
                  ov_nxt = 1'b1;
                  o_st_nxt = tts_pkg::ST_RUN; o_h_nxt = rh_r; o_s_nxt = rs_r;
                  o_l_nxt = 1'b0;
                end
                rh_nxt = ring[N-1].handle; rs_nxt = pos4;
                nrun_nxt = nrun_r + CW'(1);
              end
            end
          end
          default: ;
        endcase
        if (ctl.shift) begin
          pos_nxt = pos_r + CW'(1);
          if (pos_r == CW'(N - 1)) state_nxt = tts_pkg::FSM_EMIT;
        end
      end
      tts_pkg::FSM_EMIT: begin
        // every walked command closes with one final word here
        if (!ov_r || !out_stall) begin
          state_nxt = tts_pkg::FSM_IDLE;
          o_l_nxt = 1'b1;
          ov_nxt = 1'b1;
          case (cmd_r)
            tts_pkg::CMD_ADD: begin
              o_st_nxt = added_r ? tts_pkg::ST_ADDED : tts_pkg::ST_FULL;
              o_h_nxt = added_r ? hnd_r : 8'd0;
              o_s_nxt = added_r ? slot_w_r : 4'd0;
            end
            tts_pkg::CMD_TICK: begin
              o_st_nxt = tts_pkg::ST_TICKED; o_h_nxt = '0; o_s_nxt = '0;
            end
            tts_pkg::CMD_DISPATCH: begin
              if (nrun_r != '0) begin
                o_st_nxt = tts_pkg::ST_RUN; o_h_nxt = rh_r; o_s_nxt = rs_r;
              end else begin
                o_st_nxt = tts_pkg::ST_NONE; o_h_nxt = '0; o_s_nxt = '0;
              end
            end
            default: begin
              o_st_nxt = found_r ? tts_pkg::ST_DELETED : tts_pkg::ST_EMPTY;
              o_h_nxt = found_r ? o_h_r : 8'd0;
              o_s_nxt = sn_r;
            end
          endcase
        end
      end
      default: state_nxt = tts_pkg::FSM_IDLE;
    endcase
  end

  // hold the command, walk position, held run word and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tts_pkg::FSM_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
    cmd_r <= cmd_nxt; hnd_r <= hnd_nxt; sn_r <= sn_nxt; dly_r <= dly_nxt;
    per_r <= per_nxt; pos_r <= pos_nxt; added_r <= added_nxt; found_r <= found_nxt;
    nrun_r <= nrun_nxt; slot_w_r <= slot_w_nxt; rh_r <= rh_nxt; rs_r <= rs_nxt;
    o_st_r <= o_st_nxt; o_h_r <= o_h_nxt; o_s_r <= o_s_nxt; o_l_r <= o_l_nxt;
  end

  assign out_valid       = ov_r;
  assign out_status      = o_st_r;
  assign out_run_handle  = o_h_r;
  assign out_slot_used   = o_s_r;
  assign out_last_result = o_l_r;

endmodule
